// ----- src/hmmd_pkg.sv -----
`default_nettype none
package hmmd_pkg;

  typedef enum logic [3:0] {
    UNIT_LOCAL     = 4'd0,
    UNIT_JOYPAD    = 4'd1,
    UNIT_TIMER     = 4'd2,
    UNIT_INTERRUPT = 4'd3,
    UNIT_SOUND     = 4'd4,
    UNIT_DISPLAY   = 4'd5,
    UNIT_SPEED     = 4'd6,
    UNIT_OAM_DMA   = 4'd7,
    UNIT_HDMA      = 4'd8,
    UNIT_UNUSABLE  = 4'd9,
    UNIT_NONE      = 4'd10
  } unit_t;

  typedef enum logic [2:0] {
    SRC_IMM,
    SRC_VIDEO,
    SRC_WORK,
    SRC_OBJECT,
    SRC_HIGH
  } src_t;

  typedef struct packed {
    src_t        src;
    logic [7:0]  imm;
    unit_t       unit;
    logic        locked;
  } stage_t;

  localparam int OBJECT_BYTES = 160;
  localparam int HIGH_BYTES   = 127;

  localparam logic [15:0] VRAM_LO   = 16'h8000;
  localparam logic [15:0] VRAM_HI   = 16'h9FFF;
  localparam logic [15:0] WRAM_LO   = 16'hC000;
  localparam logic [15:0] ECHO_LO   = 16'hE000;
  localparam logic [15:0] ECHO_HI   = 16'hFDFF;
  localparam logic [15:0] ECHO_OFS  = 16'h2000;
  localparam logic [15:0] OAM_LO    = 16'hFE00;
  localparam logic [15:0] OAM_HI    = 16'hFE9F;
  localparam logic [15:0] UNUSED_LO = 16'hFEA0;
  localparam logic [15:0] UNUSED_HI = 16'hFEFF;
  localparam logic [15:0] IO_LO     = 16'hFF00;
  localparam logic [15:0] IO_HI     = 16'hFF7F;
  localparam logic [15:0] HRAM_LO   = 16'hFF80;
  localparam logic [15:0] HRAM_HI   = 16'hFFFE;
  localparam logic [15:0] IE_ADDR   = 16'hFFFF;
  localparam logic [15:0] WAVE_ADDR = 16'hFF1A;
  localparam logic [15:0] SVBK_ADDR = 16'hFF70;

  localparam logic [7:0]  WAVE_BYTE   = 8'h80;
  localparam logic [7:0]  LOCKED_BYTE = 8'hFF;

  localparam logic [1:0]  MODE_TRANSFER = 2'd3;

endpackage
`default_nettype wire

// ----- src/hmmd_ram.sv -----
`default_nettype none
module hmmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- src/handheld_memory_map_decoder.sv -----
`default_nettype none
// Each transaction passes two register stages: s1_r, then out_data_r.
// Throughput: one transaction per cycle; stalls only when out_tready is low.
// Reset (rst_n low, synchronous): clears the pipeline, sets the work bank to 1
// and colour mode to 0. Video, work, object and high RAM are not cleared.
module handheld_memory_map_decoder #(
  parameter int VIDEO_BYTES = 16384,
  parameter int WORK_BYTES  = 32768
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // address[15:0], write_data[23:16], display_mode[25:24], video_bank[26]
  input  wire logic [31:0] in_tdata,
  // opcode[0]
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // read_data[7:0], target_unit[11:8], access_locked[12]
  output logic      [15:0] out_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata
);
  import hmmd_pkg::*;

  localparam int VA_W = $clog2(VIDEO_BYTES);
  localparam int WA_W = $clog2(WORK_BYTES);
  localparam int OA_W = $clog2(OBJECT_BYTES);
  localparam int HA_W = $clog2(HIGH_BYTES);
  localparam logic [14:0] VIDEO_SZ = 15'(VIDEO_BYTES);
  localparam logic [15:0] WORK_SZ  = 16'(WORK_BYTES);

  logic        wr;
  logic [15:0] a;
  logic [7:0]  d;
  logic [1:0]  mode;
  logic        vbank;
  logic        accept;

  logic        colour_r;
  logic [2:0]  bank_r, bank_nxt;
  logic        bank_we;

  logic        s1_valid_r;
  stage_t      s1_r, dec;
  logic        s1_adv;
  logic        out_valid_r;
  logic [15:0] out_data_r, out_data_nxt;

  logic        vid_hit, work_hit, obj_hit, high_hit;
  logic [14:0] vidx;
  logic [15:0] ea, widx;
  logic [2:0]  wsel;

  logic [7:0]  vid_q, work_q, obj_q, high_q;
  logic [7:0]  rd;

  assign wr    = in_tuser;
  assign a     = in_tdata[15:0];
  assign d     = in_tdata[23:16];
  assign mode  = in_tdata[25:24];
  assign vbank = in_tdata[26];

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign accept    = in_tvalid && in_tready;

  function automatic unit_t io_unit(input logic [7:0] lo);
    unit_t u;
    u = UNIT_NONE;
    if (lo == 8'h00) u = UNIT_JOYPAD;
    else if (lo >= 8'h04 && lo <= 8'h07) u = UNIT_TIMER;
    else if (lo == 8'h0F) u = UNIT_INTERRUPT;
    else if (lo >= 8'h10 && lo <= 8'h3F) u = UNIT_SOUND;
    else if (lo == 8'h46) u = UNIT_OAM_DMA;
    else if ((lo >= 8'h40 && lo <= 8'h45) || (lo >= 8'h47 && lo <= 8'h4B) ||
             (lo >= 8'h68 && lo <= 8'h6B) || lo == 8'h4F) u = UNIT_DISPLAY;
    else if (lo == 8'h4D) u = UNIT_SPEED;
    else if (lo >= 8'h51 && lo <= 8'h55) u = UNIT_HDMA;
    else if (lo == 8'h70) u = UNIT_LOCAL;
    return u;
  endfunction

  always_comb begin
    vidx = {1'b0, vbank && colour_r, a[12:0]};
    if (vidx >= VIDEO_SZ) begin
      vidx = vidx - VIDEO_SZ;
    end
  end

  always_comb begin
    ea   = (a >= ECHO_LO) ? a - ECHO_OFS : a;
    wsel = (ea[12] && colour_r) ? bank_r : {2'b00, ea[12]};
    widx = {1'b0, wsel, ea[11:0]};
    for (int i = 0; i < 3; i++) begin
      if (widx >= WORK_SZ) begin
        widx = widx - WORK_SZ;
      end
    end
  end

  always_comb begin
    dec.src    = SRC_IMM;
    dec.imm    = 8'h00;
    dec.unit   = UNIT_LOCAL;
    dec.locked = 1'b0;
    vid_hit    = 1'b0;
    work_hit   = 1'b0;
    obj_hit    = 1'b0;
    high_hit   = 1'b0;
    bank_we    = 1'b0;
    if (a >= VRAM_LO && a <= VRAM_HI) begin
      if (mode == MODE_TRANSFER) begin
        dec.locked = 1'b1;
        dec.imm    = wr ? 8'h00 : LOCKED_BYTE;
      end else begin
        vid_hit = 1'b1;
        dec.src = wr ? SRC_IMM : SRC_VIDEO;
      end
    end else if (a >= WRAM_LO && a <= ECHO_HI) begin
      work_hit = 1'b1;
      dec.src  = wr ? SRC_IMM : SRC_WORK;
    end else if (a >= OAM_LO && a <= OAM_HI) begin
      if (!mode[1]) begin
        obj_hit = 1'b1;
        dec.src = wr ? SRC_IMM : SRC_OBJECT;
      end else begin
        dec.locked = 1'b1;
        dec.imm    = wr ? 8'h00 : LOCKED_BYTE;
      end
    end else if (a >= UNUSED_LO && a <= UNUSED_HI) begin
      dec.unit = UNIT_UNUSABLE;
    end else if (a >= IO_LO && a <= IO_HI) begin
      if (a == WAVE_ADDR && !wr) begin
        dec.imm = WAVE_BYTE;
      end else if (a == SVBK_ADDR) begin
        if (wr) begin
          bank_we = 1'b1;
        end else begin
          dec.imm = {5'b00000, bank_r};
        end
      end else begin
        dec.unit = io_unit(a[7:0]);
      end
    end else if (a >= HRAM_LO && a <= HRAM_HI) begin
      high_hit = 1'b1;
      dec.src  = wr ? SRC_IMM : SRC_HIGH;
    end else if (a == IE_ADDR) begin
      dec.unit = UNIT_INTERRUPT;
    end else begin
      dec.unit = UNIT_NONE;
    end
  end

  assign bank_nxt = (d[2:0] == 3'b000) ? 3'b001 : d[2:0];

  hmmd_ram #(.WIDTH(8), .DEPTH(VIDEO_BYTES)) u_video (
    .clk(clk), .en(accept && vid_hit), .we(wr), .addr(vidx[VA_W-1:0]),
    .wdata(d), .rdata(vid_q)
  );

  hmmd_ram #(.WIDTH(8), .DEPTH(WORK_BYTES)) u_work (
    .clk(clk), .en(accept && work_hit), .we(wr), .addr(widx[WA_W-1:0]),
    .wdata(d), .rdata(work_q)
  );

  hmmd_ram #(.WIDTH(8), .DEPTH(OBJECT_BYTES)) u_object (
    .clk(clk), .en(accept && obj_hit), .we(wr), .addr(a[OA_W-1:0]),
    .wdata(d), .rdata(obj_q)
  );

  hmmd_ram #(.WIDTH(8), .DEPTH(HIGH_BYTES)) u_high (
    .clk(clk), .en(accept && high_hit), .we(wr), .addr(a[HA_W-1:0]),
    .wdata(d), .rdata(high_q)
  );

  always_comb begin
    case (s1_r.src)
      SRC_VIDEO:  rd = vid_q;
      SRC_WORK:   rd = work_q;
      SRC_OBJECT: rd = obj_q;
      SRC_HIGH:   rd = high_q;
      default:    rd = s1_r.imm;
    endcase
    out_data_nxt = {3'b000, s1_r.locked, s1_r.unit, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colour_r    <= 1'b0;
      bank_r      <= 3'b001;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        colour_r <= cfg_wdata;
      end
      if (accept && bank_we) begin
        bank_r <= bank_nxt;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= dec;
    end
    if (s1_adv && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
